[hdl/uifr_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uifr_pkg: shared types and constants
// Payload structs and frame protocol constants.
// ----------------------------------------------------------------------------
package uifr_pkg;

  typedef struct packed {
    logic       req_type;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] tx_byte;
    logic       tx_last;
  } out_item_t;

  localparam logic       REQ_BYTE   = 1'b0;
  localparam logic       REQ_TICK   = 1'b1;
  localparam logic [7:0] HDR0       = 8'h5A;
  localparam logic [7:0] HDR1       = 8'hA5;
  localparam logic [7:0] CMD_READ   = 8'h83;
  localparam logic [7:0] CMD_WRITE  = 8'h82;
  localparam logic [7:0] READ_LEN   = 8'h04;
  localparam logic [7:0] ACK_LEN    = 8'h03;
  localparam logic [7:0] ACK_O      = 8'h4F;
  localparam logic [7:0] ACK_K      = 8'h4B;
  localparam logic [15:0] IDLE_LIMIT_RST = 16'd50;

endpackage

[hdl/uart_idle_frame_register_access_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uart_idle_frame_register_access_unit: idle-framed register access
// Collects bytes into a frame, closes it on idle timeout and serves
// read/write commands against a word memory.
// ----------------------------------------------------------------------------
//  channel | signals                  | direction | payload
//  in      | in_valid_i / in_ready_o  | input     | in_item_t (req_type, rx_byte)
//  out     | out_valid_o / out_ready_i| output    | out_item_t (tx_byte, tx_last)
//  cfg     | cfg_valid_i / cfg_ready_o| input     | idle_limit, 16 bits
//
// A received byte causes at most one write to the frame store. A closing
// tick runs a sequencer that reads the 7 header bytes from the frame store
// and checks them, then sends 7 header bytes and 2 bytes per word for a
// read, or writes each word from two frame bytes and sends 6 ack bytes for
// a write; output stalls hold the sends. A rejected frame goes back to idle
// after the check.
// The frame store and word memory each have one port.
// After reset the word memory is swept to zero, one word a cycle;
// no item is accepted during the sweep.
// ----------------------------------------------------------------------------
module uart_idle_frame_register_access_unit #(
  parameter int FRAME_BYTES   = 64,
  parameter int MEM_ADDR_BITS = 10
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  uifr_pkg::in_item_t in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output uifr_pkg::out_item_t out_data_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [15:0]        cfg_data_i
);
  import uifr_pkg::*;

  localparam int FA = $clog2(FRAME_BYTES);
  localparam int FL = $clog2(FRAME_BYTES + 1);
  localparam int MW = 1 << MEM_ADDR_BITS;

  typedef enum logic [9:0] {
    S_CLEAR = 10'b0000000001,
    S_IDLE  = 10'b0000000010,
    S_HDR   = 10'b0000000100,
    S_CHECK = 10'b0000001000,
    S_RHEAD = 10'b0000010000,
    S_RMEM  = 10'b0000100000,
    S_RLO   = 10'b0001000000,
    S_WHI   = 10'b0010000000,
    S_WLO   = 10'b0100000000,
    S_ACK   = 10'b1000000000
  } state_e;

  state_e state_q, state_d;

  // Storage.
  logic [7:0]  fstore [FRAME_BYTES];
  logic [15:0] wmem   [MW];

  // Control registers.
  logic [15:0] idle_limit_q;
  logic        recv_q;
  logic [FL-1:0] flen_q;
  logic [15:0] ticks_q;

  // Sequencer registers.
  logic [FA-1:0] fidx_q, fidx_d;     // frame store read index
  logic [2:0]    hcnt_q, hcnt_d;     // header byte in flight
  logic          frd_v_q;            // frame read data in frd_q valid
  logic [7:0]    frd_q;
  logic [7:0]    h_q [7];            // header bytes 0..6
  logic [MEM_ADDR_BITS-1:0] maddr_q, maddr_d;
  logic [8:0]    cnt_q, cnt_d;       // words left
  logic [2:0]    ack_q, ack_d;
  logic [7:0]    whi_q, whi_d;
  logic [15:0]   mrd_q;
  logic          ovalid_q;
  out_item_t     odata_q;

  logic          in_fire, out_fire, emit_free;
  logic          close_tick;
  logic [15:0]   ticks_inc;
  logic [15:0]   base_addr;

  // Memory port controls.
  logic          fwe, fre;
  logic [FA-1:0] fwa, fra;
  logic          mwe, mre;
  logic [MEM_ADDR_BITS-1:0] ma;
  logic [15:0]   mwd;
  logic          emit_v;
  out_item_t     emit_d;

  assign out_fire    = ovalid_q && out_ready_i;
  assign emit_free   = !ovalid_q || out_ready_i;
  assign in_ready_o  = (state_q == S_IDLE);
  assign in_fire     = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = ovalid_q;
  assign out_data_o  = odata_q;
  assign base_addr   = {h_q[4], h_q[5]};

  assign ticks_inc  = (ticks_q == 16'hFFFF) ? ticks_q : ticks_q + 16'd1;
  assign close_tick = in_fire && (in_data_i.req_type == REQ_TICK) && recv_q &&
                      (ticks_inc > idle_limit_q);

  // Read count n, write word count, header check, and whether a read reply fits or a write frame holds its words.
  logic [8:0] rd_n, wr_words;
  logic       rd_ok, wr_ok, hdr_ok;
  always_comb begin
    rd_n     = {1'b0, h_q[6]};
    wr_words = {2'b0, 7'((h_q[2] - 8'd3) >> 1)};
    hdr_ok   = (flen_q >= FL'(6)) && (h_q[0] == HDR0) && (h_q[1] == HDR1);
    rd_ok    = (h_q[3] == CMD_READ) && (flen_q == FL'(7)) && (h_q[2] == READ_LEN) &&
               ((11'd7 + {1'b0, rd_n, 1'b0}) <= 11'(FRAME_BYTES));
    wr_ok    = (h_q[3] == CMD_WRITE) && (h_q[2] >= ACK_LEN) &&
               ((11'd6 + {1'b0, wr_words, 1'b0}) <= {{(11 - FL){1'b0}}, flen_q});
  end

  function automatic logic [7:0] ack_byte(input logic [2:0] i);
    logic [7:0] b;
    case (i)
      3'd0:    b = HDR0;
      3'd1:    b = HDR1;
      3'd2:    b = ACK_LEN;
      3'd3:    b = CMD_WRITE;
      3'd4:    b = ACK_O;
      default: b = ACK_K;
    endcase
    return b;
  endfunction

  always_comb begin
    state_d = state_q;
    fidx_d  = fidx_q;
    hcnt_d  = hcnt_q;
    maddr_d = maddr_q;
    cnt_d   = cnt_q;
    ack_d   = ack_q;
    whi_d   = whi_q;
    fwe = 1'b0; fwa = flen_q[FA-1:0];
    fre = 1'b0; fra = fidx_q;
    mwe = 1'b0; mre = 1'b0; ma = maddr_q; mwd = '0;
    emit_v = 1'b0;
    emit_d = '{tx_byte: 8'h00, tx_last: 1'b0};
    case (state_q)
      S_CLEAR: begin
        mwe = 1'b1;
        maddr_d = maddr_q + 1'b1;
        if (maddr_q == '1) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_fire && in_data_i.req_type == REQ_BYTE) begin
          fwe = (!recv_q) || (flen_q < FL'(FRAME_BYTES));
          fwa = recv_q ? flen_q[FA-1:0] : '0;
        end
        if (close_tick) begin
          state_d = S_HDR;
          fidx_d  = '0;
          hcnt_d  = '0;
        end
      end
      S_HDR: begin
        // Stream header bytes 0..6 from the frame store.
        fre    = 1'b1;
        fidx_d = fidx_q + 1'b1;
        if (fidx_q == FA'(6)) state_d = S_CHECK;
      end
      S_CHECK: begin
        maddr_d = base_addr[MEM_ADDR_BITS-1:0];
        hcnt_d  = '0;
        if (!frd_v_q) begin
          if (!hdr_ok) state_d = S_IDLE;
          else if (rd_ok) begin
            state_d = S_RHEAD;
            cnt_d   = rd_n;
          end else if (wr_ok) begin
            state_d = (wr_words == '0) ? S_ACK : S_WHI;
            cnt_d   = wr_words;
            fidx_d  = FA'(6);
            ack_d   = '0;
          end else state_d = S_IDLE;
        end
      end
      S_RHEAD: begin
        if (emit_free) begin
          emit_v = 1'b1;
          emit_d.tx_byte = (hcnt_q == 3'd2) ? 8'(8'd4 + {rd_n[7:0], 1'b0}) : h_q[hcnt_q];
          emit_d.tx_last = (hcnt_q == 3'd6) && (cnt_q == '0);
          hcnt_d = hcnt_q + 3'd1;
          if (hcnt_q == 3'd6) begin
            if (cnt_q == '0) state_d = S_IDLE;
            else begin
              mre = 1'b1;
              state_d = S_RMEM;
            end
          end
        end
      end
      S_RMEM: begin
        // mrd_q holds the word; send the high byte.
        if (emit_free) begin
          emit_v = 1'b1;
          emit_d.tx_byte = mrd_q[15:8];
          state_d = S_RLO;
        end
      end
      S_RLO: begin
        if (emit_free) begin
          emit_v = 1'b1;
          emit_d.tx_byte = mrd_q[7:0];
          emit_d.tx_last = (cnt_q == 9'd1);
          cnt_d   = cnt_q - 9'd1;
          maddr_d = maddr_q + 1'b1;
          if (cnt_q == 9'd1) state_d = S_IDLE;
          else begin
            mre = 1'b1;
            ma  = maddr_q + 1'b1;
            state_d = S_RMEM;
          end
        end
      end
      S_WHI: begin
        // Issue the read for the hi byte of the next word; S_WLO reads the lo byte.
        fre    = 1'b1;
        fidx_d = fidx_q + 1'b1;
        state_d = S_WLO;
      end
      S_WLO: begin
        if (frd_v_q && hcnt_q == 3'd0) begin
          whi_d  = frd_q;
          hcnt_d = 3'd1;
          fre    = 1'b1;
          fidx_d = fidx_q + 1'b1;
        end else if (frd_v_q) begin
          mwe = 1'b1;
          mwd = {whi_q, frd_q};
          maddr_d = maddr_q + 1'b1;
          cnt_d   = cnt_q - 9'd1;
          hcnt_d  = 3'd0;
          state_d = (cnt_q == 9'd1) ? S_ACK : S_WHI;
        end
      end
      S_ACK: begin
        if (emit_free) begin
          emit_v = 1'b1;
          emit_d.tx_byte = ack_byte(ack_q);
          emit_d.tx_last = (ack_q == 3'd5);
          ack_d = ack_q + 3'd1;
          if (ack_q == 3'd5) state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Frame store: one write or one read per cycle.
  always_ff @(posedge clk_i) begin
    if (fwe) fstore[fwa] <= in_data_i.rx_byte;
    if (fre) frd_q <= fstore[fra];
  end

  // Word memory: one write or one read per cycle.
  always_ff @(posedge clk_i) begin
    if (mwe) wmem[ma] <= mwd;
    if (mre) mrd_q <= wmem[ma];
  end

  // Capture header bytes as they return.
  always_ff @(posedge clk_i) begin
    if (frd_v_q && (state_q == S_HDR || state_q == S_CHECK)) h_q[hcnt_q] <= frd_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_CLEAR;
      idle_limit_q <= IDLE_LIMIT_RST;
      recv_q       <= 1'b0;
      flen_q       <= '0;
      ticks_q      <= '0;
      fidx_q       <= '0;
      hcnt_q       <= '0;
      frd_v_q      <= 1'b0;
      maddr_q      <= '0;
      cnt_q        <= '0;
      ack_q        <= '0;
      whi_q        <= '0;
      ovalid_q     <= 1'b0;
      odata_q      <= '0;
    end else begin
      state_q <= state_d;
      fidx_q  <= fidx_d;
      maddr_q <= maddr_d;
      cnt_q   <= cnt_d;
      ack_q   <= ack_d;
      whi_q   <= whi_d;
      frd_v_q <= fre;
      // Header capture index advances with returning data.
      if ((state_q == S_HDR || state_q == S_CHECK) && frd_v_q) hcnt_q <= hcnt_q + 3'd1;
      else hcnt_q <= hcnt_d;
      if (cfg_valid_i) idle_limit_q <= cfg_data_i;
      if (in_fire) begin
        if (in_data_i.req_type == REQ_BYTE) begin
          ticks_q <= '0;
          recv_q  <= 1'b1;
          if (!recv_q) flen_q <= FL'(1);
          else if (flen_q < FL'(FRAME_BYTES)) flen_q <= flen_q + FL'(1);
        end else begin
          ticks_q <= ticks_inc;
          if (close_tick) recv_q <= 1'b0;
        end
      end
      // Output register: load a new byte, or drop valid on transfer.
      if (emit_v) begin
        ovalid_q <= 1'b1;
        odata_q  <= emit_d;
      end else if (out_fire) begin
        ovalid_q <= 1'b0;
      end
    end
  end

  // Assertions.
  a_no_emit_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_v |-> (!ovalid_q || out_ready_i))
    else $error("output register overwritten");
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |-> (state_q == S_IDLE))
    else $error("item accepted while sequencer busy");
  a_flen_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    flen_q <= FL'(FRAME_BYTES))
    else $error("frame length overflow");
  a_close_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    close_tick |=> !recv_q)
    else $error("frame not closed");

endmodule

[test/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: testbench for the idle-framed register access unit
// Feeds bytes and ticks through the input channel, predicts reply bytes
// from a local model of framing, decoding and word memory, and compares
// every output transfer in order. Idle limit is changed between phases.
// ----------------------------------------------------------------------------
import uifr_pkg::*;

class reply_scoreboard;
  logic [15:0] idle_limit;
  bit          receiving;
  int          frame_len;
  int unsigned idle_cnt;
  logic [7:0]  frame_buf[64];
  logic [15:0] words[1024];
  out_item_t   pending[$];
  int          errors;
  int          replies;

  function void reset_state();
    idle_limit = IDLE_LIMIT_RST;
    receiving  = 0;
    frame_len  = 0;
    idle_cnt   = 0;
    foreach (words[i]) words[i] = '0;
  endfunction

  function void push_byte(logic [7:0] b, bit last);
    out_item_t o;
    o.tx_byte = b;
    o.tx_last = last;
    pending.push_back(o);
  endfunction

  function void decode();
    int n, w;
    logic [15:0] base;
    if (frame_len < 6 || frame_buf[0] != HDR0 || frame_buf[1] != HDR1) return;
    base = {frame_buf[4], frame_buf[5]};
    if (frame_buf[3] == CMD_READ) begin
      if (frame_len != 7 || frame_buf[2] != READ_LEN) return;
      n = frame_buf[6];
      if (7 + 2 * n > 64) return;
      for (int k = 0; k < 7; k++)
        push_byte(k == 2 ? 8'(4 + 2 * n) : frame_buf[k], n == 0 && k == 6);
      for (int k = 0; k < n; k++) begin
        push_byte(words[10'(base + k)][15:8], 0);
        push_byte(words[10'(base + k)][7:0], k == n - 1);
      end
      replies++;
    end else if (frame_buf[3] == CMD_WRITE) begin
      if (frame_buf[2] < 3) return;
      w = (frame_buf[2] - 3) / 2;
      if (6 + 2 * w > frame_len) return;
      for (int k = 0; k < w; k++)
        words[10'(base + k)] = {frame_buf[6 + 2 * k], frame_buf[7 + 2 * k]};
      push_byte(HDR0, 0); push_byte(HDR1, 0); push_byte(ACK_LEN, 0);
      push_byte(CMD_WRITE, 0); push_byte(ACK_O, 0); push_byte(ACK_K, 1);
      replies++;
    end
  endfunction

  // Note an accepted input transfer and queue any reply it causes.
  function void note_input(in_item_t it);
    if (it.req_type == REQ_BYTE) begin
      idle_cnt = 0;
      if (!receiving) begin
        frame_len = 0;
        receiving = 1;
      end
      if (frame_len < 64) begin
        frame_buf[frame_len] = it.rx_byte;
        frame_len++;
      end
    end else begin
      if (idle_cnt < 65535) idle_cnt++;
      if (receiving && idle_cnt > idle_limit) begin
        decode();
        receiving = 0;
      end
    end
  endfunction

  function void check_output(out_item_t got);
    out_item_t exp_o;
    if (pending.size() == 0) begin
      $error("unexpected reply byte %h", got.tx_byte);
      errors++;
      return;
    end
    exp_o = pending.pop_front();
    if (got.tx_byte !== exp_o.tx_byte) begin
      $error("tx_byte: expected %h, actual %h", exp_o.tx_byte, got.tx_byte);
      errors++;
    end
    if (got.tx_last !== exp_o.tx_last) begin
      $error("tx_last: expected %b, actual %b", exp_o.tx_last, got.tx_last);
      errors++;
    end
  endfunction
endclass

module tb;
  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  in_item_t    in_data;
  logic        out_valid;
  logic        out_ready;
  out_item_t   out_data;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [15:0] cfg_data;

  reply_scoreboard sb;
  bit          calm;       // true while idling is switched off
  int          items_sent;

  uart_idle_frame_register_access_unit i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_data_i  (cfg_data)
  );

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  // Stall the receiver at random; hold ready high during calm stretches.
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= calm ? 1'b1 : ($urandom_range(99) >= 26);
    end
  end

  // Check every output transfer against the oldest expected reply byte.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_output(out_data);
  end

  // Drive one input transfer; random gap first, then hold until accepted.
  // Valid stays high after the transfer so back-to-back items need no gap.
  task automatic send(logic kind, logic [7:0] b);
    in_item_t it;
    it.req_type = kind;
    it.rx_byte  = b;
    while (!calm && $urandom_range(99) < 26) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
    sb.note_input(it);
    items_sent++;
  endtask

  task automatic send_bytes(logic [7:0] q[$]);
    foreach (q[i]) send(REQ_BYTE, q[i]);
  endtask

  // Advance idle time until any open frame has closed.
  task automatic close_frame();
    int n;
    n = sb.idle_limit + 2 - sb.idle_cnt;
    if (n < 1) n = 1;
    repeat (n) send(REQ_TICK, 8'($urandom));
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic write_limit(logic [15:0] v);
    drain();
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    sb.idle_limit = v;
    cfg_valid <= 1'b0;
  endtask

  task automatic do_write(logic [15:0] a, int w, int extra);
    logic [7:0] q[$];
    q = '{HDR0, HDR1, 8'(3 + 2 * w), CMD_WRITE, a[15:8], a[7:0]};
    repeat (2 * w + extra) q.push_back(8'($urandom));
    send_bytes(q);
    close_frame();
  endtask

  task automatic do_read(logic [15:0] a, logic [7:0] n);
    send_bytes('{HDR0, HDR1, READ_LEN, CMD_READ, a[15:8], a[7:0], n});
    close_frame();
  endtask

  task automatic random_frame();
    logic [7:0] q[$];
    int r;
    r = $urandom_range(99);
    if (r < 35) do_write(16'($urandom), $urandom_range(5), $urandom_range(2));
    else if (r < 70) do_read(16'($urandom), 8'($urandom_range(29)));
    else begin
      // Broken header, wrong length, odd command or plain noise.
      q = '{HDR0, HDR1, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom)};
      if ($urandom_range(1)) q[0] = 8'($urandom);
      if ($urandom_range(1)) q[3] = $urandom_range(1) ? CMD_READ : CMD_WRITE;
      repeat ($urandom_range(4)) q.push_back(8'($urandom));
      repeat ($urandom_range(3)) void'(q.pop_back());
      send_bytes(q);
      close_frame();
    end
  endtask

  initial begin
    sb = new();
    sb.reset_state();
    calm       = 0;
    items_sent = 0;
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_data    = '0;
    cfg_valid  = 1'b0;
    cfg_data   = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: short limit, then full write/read, special cases.
    write_limit(16'd2);
    do_write(16'hFFFF, 2, 0);                 // wrap at end of memory
    do_read(16'h03FF, 8'd2);
    do_read(16'h0000, 8'd28);                 // largest read that fits
    do_read(16'h0000, 8'd29);                 // reply too long: dropped
    do_read(16'h0000, 8'd0);
    send_bytes('{HDR0, HDR1, 8'h02, CMD_WRITE, 8'h00, 8'h00});  // len below 3
    close_frame();
    send_bytes('{HDR0, HDR1});                // too short
    close_frame();
    repeat (3) send(REQ_TICK, 8'hFF);         // ticks while idle
    repeat (70) send(REQ_BYTE, 8'($urandom)); // overflow of the frame buffer
    close_frame();
    do_write(16'h1234, 29, 0);                // maximum payload that fits

    // Random frames with a calm stretch and new limits between phases.
    write_limit(16'd0);
    while (items_sent < 300) begin
      calm = (items_sent >= 250);
      random_frame();
      if ($urandom_range(15) == 0) write_limit(16'($urandom_range(4)));
    end
    calm = 0;
    write_limit(16'hFFFF);
    send_bytes('{HDR0, HDR1, READ_LEN, CMD_READ, 8'h00, 8'h10, 8'h03});
    repeat (40) send(REQ_TICK, 8'h00);        // limit never reached here
    write_limit(16'd1);
    close_frame();
    do_read(16'h0010, 8'd3);
    drain();

    $display("Covered %0d input transfers, %0d replies, idle limit 0 to 65535.",
             items_sent, sb.replies);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #40ms;
    $display("RESULT: ERROR");
    $finish;
  end
endmodule

[filelist.f]
hdl/uifr_pkg.sv
hdl/uart_idle_frame_register_access_unit.sv
test/tb.sv
